>>> rtl/core/avc_crl_pkg.sv
// ----------------------------------------------------------------------------
// avc_crl_pkg
// Types and constants shared by the AVC configuration record length finder.
// ----------------------------------------------------------------------------
package avc_crl_pkg;

  localparam int unsigned LEN_W        = 25;
  localparam logic [2:0]  HEADER_BYTES = 3'd5;
  localparam logic [7:0]  SPS_COUNT_MASK = 8'h1F;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_HEADER  = 3'd1,
    PH_COUNT   = 3'd2,
    PH_LEN_HI  = 3'd3,
    PH_LEN_LO  = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_DONE    = 3'd6
  } phase_t;

  typedef enum logic {
    ST_COMPLETE  = 1'b0,
    ST_TRUNCATED = 1'b1
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       record_start;
    logic       stream_end;
  } in_t;

  typedef struct packed {
    logic [LEN_W-1:0] record_length;
    logic             status;
  } out_t;

endpackage

>>> rtl/core/avc_crl_parser.sv
// ----------------------------------------------------------------------------
// avc_crl_parser
// Per-byte record walker: header skip, set counts, set lengths, payload skip.
// ----------------------------------------------------------------------------
module avc_crl_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               byte_vld,
  input  avc_crl_pkg::in_t   byte_in,
  output logic               res_vld,
  output avc_crl_pkg::out_t  res
);

  avc_crl_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]  sets_r, sets_nxt;
  logic [7:0]  len_hi_r, len_hi_nxt;
  logic [15:0] pay_r, pay_nxt;
  logic        pic_r, pic_nxt;
  logic [avc_crl_pkg::LEN_W-1:0] total_r, total_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= avc_crl_pkg::PH_IDLE;
      hdr_cnt_r <= '0;
      sets_r    <= '0;
      len_hi_r  <= '0;
      pay_r     <= '0;
      pic_r     <= 1'b0;
      total_r   <= '0;
    end else if (byte_vld) begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      sets_r    <= sets_nxt;
      len_hi_r  <= len_hi_nxt;
      pay_r     <= pay_nxt;
      pic_r     <= pic_nxt;
      total_r   <= total_nxt;
    end
  end

  always_comb begin
    logic done;
    logic adv;
    done = 1'b0;
    adv  = 1'b0;
    // start of record clears everything before the byte is taken
    if (byte_in.record_start) begin
      phase_nxt   = avc_crl_pkg::PH_HEADER;
      hdr_cnt_nxt = '0;
      sets_nxt    = '0;
      len_hi_nxt  = '0;
      pay_nxt     = '0;
      pic_nxt     = 1'b0;
      total_nxt   = '0;
    end else begin
      phase_nxt   = phase_r;
      hdr_cnt_nxt = hdr_cnt_r;
      sets_nxt    = sets_r;
      len_hi_nxt  = len_hi_r;
      pay_nxt     = pay_r;
      pic_nxt     = pic_r;
      total_nxt   = total_r;
    end
    res_vld           = 1'b0;
    res.record_length = '0;
    res.status        = avc_crl_pkg::ST_COMPLETE;

    if (phase_nxt != avc_crl_pkg::PH_IDLE && phase_nxt != avc_crl_pkg::PH_DONE) begin
      total_nxt = total_nxt + 1'b1;
      case (phase_nxt)
        avc_crl_pkg::PH_HEADER: begin
          hdr_cnt_nxt = hdr_cnt_nxt + 1'b1;
          if (hdr_cnt_nxt >= avc_crl_pkg::HEADER_BYTES) begin
            phase_nxt = avc_crl_pkg::PH_COUNT;
          end
        end
        avc_crl_pkg::PH_COUNT: begin
          sets_nxt = pic_nxt ? byte_in.data_byte
                             : (byte_in.data_byte & avc_crl_pkg::SPS_COUNT_MASK);
          adv = 1'b1;
        end
        avc_crl_pkg::PH_LEN_HI: begin
          len_hi_nxt = byte_in.data_byte;
          phase_nxt  = avc_crl_pkg::PH_LEN_LO;
        end
        avc_crl_pkg::PH_LEN_LO: begin
          pay_nxt  = {len_hi_nxt, byte_in.data_byte};
          sets_nxt = sets_nxt - 1'b1;
          if (pay_nxt == 16'd0) begin
            adv = 1'b1;
          end else begin
            phase_nxt = avc_crl_pkg::PH_PAYLOAD;
          end
        end
        default: begin
          pay_nxt = pay_nxt - 1'b1;
          if (pay_nxt == 16'd0) begin
            adv = 1'b1;
          end
        end
      endcase

      // next set, switch to picture sets, or end of record
      if (adv) begin
        if (sets_nxt != 8'd0) begin
          phase_nxt = avc_crl_pkg::PH_LEN_HI;
        end else if (!pic_nxt) begin
          pic_nxt   = 1'b1;
          phase_nxt = avc_crl_pkg::PH_COUNT;
        end else begin
          phase_nxt = avc_crl_pkg::PH_DONE;
          done      = 1'b1;
        end
      end

      if (done) begin
        res_vld           = 1'b1;
        res.record_length = total_nxt;
        res.status        = avc_crl_pkg::ST_COMPLETE;
      end else if (byte_in.stream_end) begin
        phase_nxt         = avc_crl_pkg::PH_DONE;
        res_vld           = 1'b1;
        res.record_length = total_nxt;
        res.status        = avc_crl_pkg::ST_TRUNCATED;
      end
    end
  end

endmodule

>>> rtl/core/avc_crl_outbuf.sv
// ----------------------------------------------------------------------------
// avc_crl_outbuf
// Output register with a skid stage; decouples parser from downstream stalls.
// ----------------------------------------------------------------------------
module avc_crl_outbuf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  avc_crl_pkg::out_t  push_data,
  output logic               can_push,
  output logic               out_valid,
  input  logic               out_ready,
  output avc_crl_pkg::out_t  out_data
);

  logic              out_vld_r, out_vld_nxt;
  logic              skid_vld_r, skid_vld_nxt;
  avc_crl_pkg::out_t out_r, out_nxt;
  avc_crl_pkg::out_t skid_r, skid_nxt;
  logic              free;

  assign can_push  = !skid_vld_r;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;
  assign free      = !out_vld_r || out_ready;

  always_comb begin
    out_vld_nxt  = out_vld_r;
    skid_vld_nxt = skid_vld_r;
    out_nxt      = out_r;
    skid_nxt     = skid_r;
    if (skid_vld_r) begin
      // no push possible while the skid stage is occupied
      if (free) begin
        out_nxt      = skid_r;
        out_vld_nxt  = 1'b1;
        skid_vld_nxt = 1'b0;
      end
    end else if (free) begin
      out_nxt     = push_data;
      out_vld_nxt = push;
    end else if (push) begin
      skid_nxt     = push_data;
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

endmodule

>>> rtl/core/avc_config_record_length.sv
// ----------------------------------------------------------------------------
// avc_config_record_length
// Finds the byte length of an AVC decoder configuration record.
// ----------------------------------------------------------------------------
// While in_ready is high one record byte is taken per cycle; each updates
// the walker state in the cycle it is accepted, and a result (record
// length, status) is registered in an output stage (output register plus
// skid) that keeps input accepted while a result waits; in_ready drops
// only when its two entries both hold results. Status 1 means the byte
// marked stream_end arrived before the record finished; the length is
// then the bytes seen. Bytes outside a record are dropped until record_start.
module avc_config_record_length (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  avc_crl_pkg::in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output avc_crl_pkg::out_t  out_data
);

  logic              acc;
  logic              res_vld;
  avc_crl_pkg::out_t res;

  assign acc = in_valid && in_ready;

  avc_crl_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (acc),
    .byte_in  (in_data),
    .res_vld  (res_vld),
    .res      (res)
  );

  avc_crl_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (acc && res_vld),
    .push_data (res),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> rtl/core/avc_crl_checker.sv
// ----------------------------------------------------------------------------
// avc_crl_checker
// Port-level checks for the record length finder, bound to the top level.
// ----------------------------------------------------------------------------
module avc_crl_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_ready,
  input  logic               out_valid,
  input  logic               out_ready,
  input  avc_crl_pkg::out_t  out_data
);

  // a held result must not change or vanish
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // input only stalls when a result is already waiting
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

  // a complete record has header, two counts at minimum
  a_min_complete: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == avc_crl_pkg::ST_COMPLETE
      |-> out_data.record_length >= 25'd7)
    else $error("complete record shorter than seven bytes");

  a_min_trunc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == avc_crl_pkg::ST_TRUNCATED
      |-> out_data.record_length != 25'd0)
    else $error("truncated record with zero length");

endmodule

bind avc_config_record_length avc_crl_checker u_avc_crl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> verif/avc_config_record_length_tb.sv
// ----------------------------------------------------------------------------
// avc_config_record_length_tb
// Self-checking bench for the AVC configuration record length finder. Record
// bytes are driven through the valid/ready input. A byte-level model of the
// record walker queues the expected length and status of each complete or
// truncated record, and each result is checked against the oldest entry.
// Directed records come first, then random record streams with truncations,
// restarts and stray bytes, under several input and output pacing modes.
// ----------------------------------------------------------------------------
module avc_config_record_length_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  avc_crl_pkg::in_t  in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  avc_crl_pkg::out_t out_data;

  // pacing knobs, percent of cycles
  int idle_pct = 0;
  int stall_pct = 0;

  int cycle_count = 0;
  int error_count = 0;
  int bytes_taken = 0;
  int bytes_ignored = 0;
  int truncated_expected = 0;
  int results_checked = 0;

  // walker model state
  avc_crl_pkg::phase_t           rec_phase = avc_crl_pkg::PH_IDLE;
  logic [2:0]                    hdr_taken = '0;
  logic [7:0]                    sets_rem = '0;
  logic [7:0]                    len_high_byte = '0;
  logic [15:0]                   payload_rem = '0;
  logic                          in_pps = 1'b0;
  logic [avc_crl_pkg::LEN_W-1:0] byte_count = '0;

  avc_crl_pkg::out_t expected_lengths[$];
  logic [7:0]        record_bytes[$];

  avc_config_record_length u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    avc_crl_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_lengths.size() == 0) begin
        $error("unexpected result: record_length %0d status %0d",
               out_data.record_length, out_data.status);
        error_count++;
      end else begin
        want = expected_lengths.pop_front();
        results_checked++;
        if (out_data.record_length !== want.record_length) begin
          $error("record_length mismatch: expected %0d, got %0d",
                 want.record_length, out_data.record_length);
          error_count++;
        end
        if (out_data.status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, out_data.status);
          error_count++;
        end
      end
    end
  end

  // After a count or a finished set: next set, the picture set count, or done.
  function automatic logic finish_or_next_set();
    if (sets_rem != 8'd0) begin
      rec_phase = avc_crl_pkg::PH_LEN_HI;
      return 1'b0;
    end
    if (!in_pps) begin
      in_pps = 1'b1;
      rec_phase = avc_crl_pkg::PH_COUNT;
      return 1'b0;
    end
    rec_phase = avc_crl_pkg::PH_DONE;
    return 1'b1;
  endfunction

  task automatic walk_record_byte(input avc_crl_pkg::in_t item);
    logic              done;
    avc_crl_pkg::out_t res;
    done = 1'b0;
    if (item.record_start) begin
      rec_phase = avc_crl_pkg::PH_HEADER;
      hdr_taken = '0;
      sets_rem = '0;
      len_high_byte = '0;
      payload_rem = '0;
      in_pps = 1'b0;
      byte_count = '0;
    end
    if (rec_phase == avc_crl_pkg::PH_IDLE || rec_phase == avc_crl_pkg::PH_DONE) begin
      bytes_ignored++;
      return;
    end
    bytes_taken++;
    byte_count = byte_count + 1'b1;
    case (rec_phase)
      avc_crl_pkg::PH_HEADER: begin
        hdr_taken = hdr_taken + 3'd1;
        if (hdr_taken >= avc_crl_pkg::HEADER_BYTES) rec_phase = avc_crl_pkg::PH_COUNT;
      end
      avc_crl_pkg::PH_COUNT: begin
        sets_rem = in_pps ? item.data_byte
                          : (item.data_byte & avc_crl_pkg::SPS_COUNT_MASK);
        done = finish_or_next_set();
      end
      avc_crl_pkg::PH_LEN_HI: begin
        len_high_byte = item.data_byte;
        rec_phase = avc_crl_pkg::PH_LEN_LO;
      end
      avc_crl_pkg::PH_LEN_LO: begin
        payload_rem = {len_high_byte, item.data_byte};
        sets_rem = sets_rem - 8'd1;
        if (payload_rem == 16'd0) done = finish_or_next_set();
        else rec_phase = avc_crl_pkg::PH_PAYLOAD;
      end
      default: begin
        payload_rem = payload_rem - 16'd1;
        if (payload_rem == 16'd0) done = finish_or_next_set();
      end
    endcase
    if (done) begin
      res.record_length = byte_count;
      res.status = avc_crl_pkg::ST_COMPLETE;
      expected_lengths.push_back(res);
    end else if (item.stream_end) begin
      rec_phase = avc_crl_pkg::PH_DONE;
      res.record_length = byte_count;
      res.status = avc_crl_pkg::ST_TRUNCATED;
      expected_lengths.push_back(res);
      truncated_expected++;
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
    avc_crl_pkg::in_t item;
    item.data_byte = b;
    item.record_start = first;
    item.stream_end = last;
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    walk_record_byte(item);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (expected_lengths.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_set_length();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 16'($urandom_range(0, 4));
    if (r < 95) return 16'($urandom_range(5, 24));
    return 16'($urandom_range(256, 270));
  endfunction

  task automatic add_param_set(input logic tiny_len);
    logic [15:0] len;
    len = tiny_len ? 16'($urandom_range(0, 1)) : pick_set_length();
    record_bytes.push_back(len[15:8]);
    record_bytes.push_back(len[7:0]);
    repeat (int'(len)) record_bytes.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic build_record();
    int         sps_cnt;
    int         pps_cnt;
    logic [2:0] spare_bits;
    logic       tiny_len;
    record_bytes.delete();
    repeat (5) record_bytes.push_back(8'($urandom_range(0, 255)));
    sps_cnt = $urandom_range(0, 3);
    spare_bits = 3'($urandom_range(0, 7));
    record_bytes.push_back({spare_bits, 5'(sps_cnt)});
    for (int i = 0; i < sps_cnt; i++) add_param_set(1'b0);
    // now and then a picture set count that needs the full byte
    tiny_len = ($urandom_range(99) < 5);
    pps_cnt = tiny_len ? $urandom_range(32, 40) : $urandom_range(0, 3);
    record_bytes.push_back(8'(pps_cnt));
    for (int i = 0; i < pps_cnt; i++) add_param_set(tiny_len);
  endtask

  task automatic test_ignored_bytes();
    idle_pct = 0;
    stall_pct = 0;
    send_byte(8'hFF, 1'b0, 1'b1);
    send_byte(8'h00, 1'b0, 1'b0);
    wait_results_drained();
  endtask

  // empty groups; upper bits of the sequence set count must be masked off
  task automatic test_minimal_record();
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'hE0, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b1);
    wait_results_drained();
  endtask

  // old record abandoned; new one has a zero-length set and a one-byte set
  task automatic test_restart_mid_record();
    send_byte(8'h01, 1'b1, 1'b0);
    send_byte(8'h64, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h01, 1'b1, 1'b0);
    send_byte(8'h5A, 1'b0, 1'b0);
    send_byte(8'hA5, 1'b0, 1'b0);
    send_byte(8'h1F, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'hE1, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h01, 1'b0, 1'b0);
    send_byte(8'hAB, 1'b0, 1'b0);
    wait_results_drained();
  endtask

  // stream ends in the header; the byte after it is dropped
  task automatic test_early_end();
    send_byte(8'h11, 1'b1, 1'b0);
    send_byte(8'h22, 1'b0, 1'b0);
    send_byte(8'h33, 1'b0, 1'b1);
    send_byte(8'h44, 1'b0, 1'b1);
    wait_results_drained();
  endtask

  task automatic test_random_stream(input int send_idle, input int recv_stall,
                                    input int n_items);
    int   taken_at_start;
    int   kind;
    int   cut;
    logic end_on_last;
    idle_pct = send_idle;
    stall_pct = recv_stall;
    taken_at_start = bytes_taken;
    while (bytes_taken - taken_at_start < n_items) begin
      kind = $urandom_range(99);
      if (kind < 10) begin
        // stray bytes, taken only if a record was left open
        repeat ($urandom_range(1, 4))
          send_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
      end else begin
        build_record();
        if (kind < 20) begin
          cut = $urandom_range(0, record_bytes.size() - 2);
          for (int i = 0; i <= cut; i++)
            send_byte(record_bytes[i], i == 0, i == cut);
          for (int i = cut + 1; i < record_bytes.size() && i <= cut + 3; i++)
            send_byte(record_bytes[i], 1'b0, 1'b0);
        end else if (kind < 28) begin
          // abandoned partway; the next record's start restarts the walk
          cut = $urandom_range(0, record_bytes.size() - 2);
          for (int i = 0; i <= cut; i++)
            send_byte(record_bytes[i], i == 0, 1'b0);
        end else begin
          end_on_last = 1'($urandom_range(0, 1));
          for (int i = 0; i < record_bytes.size(); i++)
            send_byte(record_bytes[i], i == 0,
                      end_on_last && (i == record_bytes.size() - 1));
        end
      end
    end
    wait_results_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_ignored_bytes();
    test_minimal_record();
    test_restart_mid_record();
    test_early_end();
    test_random_stream(0, 0, 240);
    test_random_stream(63, 0, 240);
    test_random_stream(0, 63, 240);
    test_random_stream(18, 18, 230);

    repeat (10) @(posedge clk);
    $display("Walked %0d record bytes and dropped %0d stray ones under four pacing modes.",
             bytes_taken, bytes_ignored);
    $display("Checked %0d record lengths, %0d of them from truncated buffers.",
             results_checked, truncated_expected);
    if (error_count == 0 && expected_lengths.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/avc_crl_pkg.sv
rtl/core/avc_crl_parser.sv
rtl/core/avc_crl_outbuf.sv
rtl/core/avc_config_record_length.sv
rtl/core/avc_crl_checker.sv
verif/avc_config_record_length_tb.sv
